// File: design/fra_pkg.sv
// Shared types and constants for the frame ramp animator.
// Used by every module of the block; depends on nothing.
package fra_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_TARGET = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_ONE_SHOT  = 2'd0,
    MODE_PING_PONG = 2'd1,
    MODE_LOOP      = 2'd2,
    MODE_CHASE     = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [1:0] CFG_IDX_STEP  = 2'd1;
  localparam logic [1:0] CFG_IDX_LIMIT = 2'd2;

  localparam int STEP_BITS = 15;
  localparam int CFG_DATA_BITS = 16;
  localparam int VALUE_BITS = 16;

  typedef struct packed {
    mode_t                mode;
    logic [STEP_BITS-1:0] step_size;
    logic [STEP_BITS-1:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic done;
    logic reversing;
  } status_t;

endpackage

// File: design/fra_cfg.sv
// Configuration register file of the frame ramp animator.
// Depends on fra_pkg for the register indexes and the cfg_t struct.
module fra_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [fra_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output fra_pkg::cfg_t                       cfg
);

  fra_pkg::cfg_t cfg_r;
  fra_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        fra_pkg::CFG_IDX_MODE:  cfg_nxt.mode = fra_pkg::mode_t'(cfg_data[1:0]);
        fra_pkg::CFG_IDX_STEP:  cfg_nxt.step_size = cfg_data[fra_pkg::STEP_BITS-1:0];
        fra_pkg::CFG_IDX_LIMIT: cfg_nxt.frame_limit = cfg_data[fra_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= fra_pkg::MODE_ONE_SHOT;
      cfg_r.step_size   <= fra_pkg::STEP_BITS'(1);
      cfg_r.frame_limit <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/fra_state.sv
// Channel state registers and the per-event update logic of the animator.
// Depends on fra_pkg for the event kinds, modes and status struct.
module fra_state #(
  parameter int FRAME_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  fra_pkg::kind_t                        kind,
  input  logic signed [fra_pkg::VALUE_BITS-1:0] target_value,
  input  fra_pkg::cfg_t                         cfg,
  output logic signed [fra_pkg::VALUE_BITS-1:0] frame_report,
  output fra_pkg::status_t                      status_nxt
);

  localparam int SW = ((FRAME_BITS > fra_pkg::VALUE_BITS) ? FRAME_BITS
                                                          : fra_pkg::VALUE_BITS) + 2;
  localparam logic signed [SW-1:0] FMAX =
    SW'((longint'(1) <<< (FRAME_BITS - 1)) - longint'(1));
  localparam logic signed [SW-1:0] FMIN = -FMAX - SW'(1);

  logic signed [FRAME_BITS-1:0]          frame_r;
  logic signed [FRAME_BITS-1:0]          frame_nxt;
  logic signed [fra_pkg::VALUE_BITS-1:0] target_r;
  logic signed [fra_pkg::VALUE_BITS-1:0] target_nxt;
  fra_pkg::status_t                      status_r;

  logic signed [SW-1:0] fw, sw, lraw, limw, traw, tgtw, up, dn;
  logic signed [SW-1:0] tick_f, ev_f, sat_f, ext_f;
  fra_pkg::status_t     tick_s;

  assign fw   = SW'(frame_r);
  assign sw   = signed'(SW'(cfg.step_size));
  assign lraw = signed'(SW'(cfg.frame_limit));
  assign limw = (lraw > FMAX) ? FMAX : lraw;
  assign traw = SW'(target_r);
  assign tgtw = (traw > FMAX) ? FMAX : ((traw < FMIN) ? FMIN : traw);
  assign up   = fw + sw;
  assign dn   = fw - sw;

  always_comb begin
    tick_f = fw;
    tick_s = status_r;
    if (status_r.active && !status_r.done) begin
      unique case (cfg.mode)
        fra_pkg::MODE_ONE_SHOT: begin
          tick_f = up;
          if (up >= limw) begin
            tick_f = limw;
            tick_s.done = 1'b1;
          end
        end
        fra_pkg::MODE_PING_PONG, fra_pkg::MODE_LOOP: begin
          if (!status_r.reversing) begin
            tick_f = up;
            if (up >= limw) begin
              tick_f = limw;
              tick_s.reversing = 1'b1;
            end
          end else begin
            tick_f = dn;
            if (dn <= SW'(0)) begin
              tick_f = '0;
              if (cfg.mode == fra_pkg::MODE_PING_PONG) begin
                tick_s.done = 1'b1;
              end else begin
                tick_s.reversing = 1'b0;
              end
            end
          end
        end
        fra_pkg::MODE_CHASE: begin
          if (fw < tgtw) begin
            tick_f = (up > tgtw) ? tgtw : up;
          end else if (fw > tgtw) begin
            tick_f = (dn < tgtw) ? tgtw : dn;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ev_f       = fw;
    status_nxt = status_r;
    target_nxt = target_r;
    unique case (kind)
      fra_pkg::KIND_TICK: begin
        ev_f       = tick_f;
        status_nxt = tick_s;
      end
      fra_pkg::KIND_START: begin
        ev_f                 = '0;
        status_nxt.active    = 1'b1;
        status_nxt.done      = 1'b0;
        status_nxt.reversing = 1'b0;
      end
      fra_pkg::KIND_STOP:   status_nxt.active = 1'b0;
      fra_pkg::KIND_TARGET: target_nxt = target_value;
      default: ;
    endcase
  end

  assign sat_f        = (ev_f > FMAX) ? FMAX : ((ev_f < FMIN) ? FMIN : ev_f);
  assign frame_nxt    = FRAME_BITS'(sat_f);
  assign ext_f        = SW'(frame_nxt);
  assign frame_report = ext_f[fra_pkg::VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r  <= '0;
      target_r <= '0;
      status_r <= '0;
    end else if (en) begin
      frame_r  <= frame_nxt;
      target_r <= target_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// File: design/frame_ramp_animator.sv
// Top level of the frame ramp animator: input register, state update, result register.
// Depends on fra_pkg, fra_cfg and fra_state.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------------
//   in       | in_valid / in_ready    | in_kind, in_target_value
//   out      | out_valid / out_ready  | out_frame_value, out_is_active/done/reversing
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Items pass the input, then the result register; one per cycle when not stalled.
// The single state update between the input and result registers sets that rate.
// Reset clears the channel state and loads the register defaults.
// A stalled result holds in the output register while one more item waits in the input one.
module frame_ramp_animator #(
  parameter int FRAME_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_kind,
  input  logic signed [fra_pkg::VALUE_BITS-1:0] in_target_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fra_pkg::VALUE_BITS-1:0] out_frame_value,
  output logic                                  out_is_active,
  output logic                                  out_is_done,
  output logic                                  out_is_reversing,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [fra_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  fra_pkg::cfg_t                         cfg;
  logic                                  in_valid_r;
  fra_pkg::kind_t                        in_kind_r;
  logic signed [fra_pkg::VALUE_BITS-1:0] in_target_r;
  logic                                  out_valid_r;
  logic signed [fra_pkg::VALUE_BITS-1:0] out_frame_r;
  fra_pkg::status_t                      out_status_r;
  logic signed [fra_pkg::VALUE_BITS-1:0] frame_report;
  fra_pkg::status_t                      status_nxt;
  logic                                  advance;

  fra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fra_state #(
    .FRAME_BITS (FRAME_BITS)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .kind         (in_kind_r),
    .target_value (in_target_r),
    .cfg          (cfg),
    .frame_report (frame_report),
    .status_nxt   (status_nxt)
  );

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind_r   <= fra_pkg::kind_t'(in_kind);
      in_target_r <= in_target_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_frame_r  <= frame_report;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_value  = out_frame_r;
  assign out_is_active    = out_status_r.active;
  assign out_is_done      = out_status_r.done;
  assign out_is_reversing = out_status_r.reversing;

endmodule

// File: design/fra_checker.sv
// Port-level checks for the frame ramp animator, bound to the top level.
// Depends on fra_pkg for the event kind codes.
module fra_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [1:0]                            in_kind,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [fra_pkg::VALUE_BITS-1:0] out_frame_value,
  input logic                                  out_is_active,
  input logic                                  out_is_done,
  input logic                                  out_is_reversing
);

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result channel is valid right after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_value)
      && $stable(out_is_active) && $stable(out_is_done) && $stable(out_is_reversing))
    else $error("Stalled result item changed.");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == fra_pkg::KIND_START) ##1 out_free |=>
      out_valid && out_is_active && !out_is_done && !out_is_reversing
      && out_frame_value == '0)
    else $error("Start item did not report a cleared, active channel.");

  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == fra_pkg::KIND_STOP) ##1 out_free |=> out_valid && !out_is_active)
    else $error("Stop item reported an active channel.");

endmodule

bind frame_ramp_animator fra_checker u_fra_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_value  (out_frame_value),
  .out_is_active    (out_is_active),
  .out_is_done      (out_is_done),
  .out_is_reversing (out_is_reversing)
);
